/* rtl/core/byte_ring_buffer_top_defines.svh */
// assertion macros shared by the byte ring buffer rtl
`ifndef BYTE_RING_BUFFER_TOP_DEFINES_SVH
`define BYTE_RING_BUFFER_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define BRB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define BRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/brb_pkg.sv */
// shared constants, codes and payload types of the byte ring buffer
package brb_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = 6;
  localparam int BYTE_W = 8;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_DROP  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic              start_req;
    logic [CNT_W-1:0]  length;
    logic [BYTE_W-1:0] write_byte;
  } brb_in_t;

  typedef struct packed {
    status_t           status;
    logic [CNT_W-1:0]  count;
    logic [BYTE_W-1:0] read_byte;
    logic              last;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  free_count;
  } brb_out_t;

endpackage

/* rtl/core/brb_ram.sv */
// generic single-write, single-read ram with registered read data
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

/* rtl/core/byte_ring_buffer_top.sv */
// byte ring buffer top level: pointer and transaction control around the byte ram
// A command is taken when start is high and busy is low, and each result shows
// for one cycle with out_valid high, in the cycle after the command or byte that
// caused it; the receiver cannot stall. A write byte, a drop, a refused or empty
// read and an unused command each give one result. A read of n bytes issues one
// ram read per cycle through the single read port, busy stays high after acceptance
// until the last ram read is issued, and the n bytes come out on consecutive
// cycles. The ram holds DEPTH bytes, at most DEPTH-1 of them in use. It needs no
// clearing pass after reset: a read only ever reaches slots between tail and
// head, which have all been written first.
`include "byte_ring_buffer_top_defines.svh"

module byte_ring_buffer_top
  import brb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  brb_in_t  in_data,
  output logic     out_valid,
  output brb_out_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  localparam logic [CNT_W:0]   DEPTH_X = (CNT_W+1)'(DEPTH);
  localparam logic [CNT_W-1:0] MAX_USED = CNT_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  rd_left_r, rd_left_nxt;
  logic [CNT_W-1:0]  wrem_r, wrem_nxt;
  logic              wref_r, wref_nxt;
  logic              out_vld_r, out_vld_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [CNT_W-1:0]  res_count_r, res_count_nxt;
  logic              res_last_r, res_last_nxt;
  logic [CNT_W-1:0]  res_used_r, res_used_nxt;
  logic [CNT_W-1:0]  res_free_r, res_free_nxt;
  logic              res_rd_r, res_rd_nxt;

  logic              accept;
  logic [CNT_W:0]    used_x;
  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  free;
  logic [CNT_W:0]    tail_sum;
  logic [PTR_W-1:0]  tail_adv;
  logic              wr_en;
  logic              rd_en;
  logic [PTR_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;

  function automatic logic [PTR_W-1:0] adv1(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  assign busy   = (state_r == S_READ);
  assign accept = start && !busy;

  assign used_x = (head_r >= tail_r) ? ((CNT_W+1)'(head_r) - (CNT_W+1)'(tail_r))
                                     : (DEPTH_X + (CNT_W+1)'(head_r) - (CNT_W+1)'(tail_r));
  assign used = used_x[CNT_W-1:0];
  assign free = MAX_USED - used;

  // tail moved by a whole read or drop, wrapped once
  always_comb begin
    tail_sum = (CNT_W+1)'(tail_r) + (CNT_W+1)'(in_data.length);
    if (tail_sum >= DEPTH_X) begin
      tail_sum = tail_sum - DEPTH_X;
    end
    tail_adv = tail_sum[PTR_W-1:0];
  end

  assign rd_addr = (state_r == S_READ) ? rd_ptr_r : tail_r;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    rd_ptr_nxt     = rd_ptr_r;
    rd_left_nxt    = rd_left_r;
    wrem_nxt       = wrem_r;
    wref_nxt       = wref_r;
    out_vld_nxt    = 1'b0;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    res_last_nxt   = res_last_r;
    res_used_nxt   = res_used_r;
    res_free_nxt   = res_free_r;
    res_rd_nxt     = res_rd_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_vld_nxt    = 1'b1;
          res_status_nxt = ST_REFUSED;
          res_count_nxt  = '0;
          res_last_nxt   = 1'b1;
          res_used_nxt   = used;
          res_free_nxt   = free;
          res_rd_nxt     = 1'b0;
          unique case (in_data.cmd)
            CMD_WRITE: begin
              if (in_data.start_req) begin
                if (in_data.length > free) begin
                  wrem_nxt     = in_data.length - 1'b1;
                  wref_nxt     = (wrem_nxt != '0);
                  res_last_nxt = (wrem_nxt == '0);
                end else if (in_data.length == '0) begin
                  wrem_nxt       = '0;
                  wref_nxt       = 1'b0;
                  res_status_nxt = ST_OK;
                end else begin
                  wr_en          = 1'b1;
                  head_nxt       = adv1(head_r);
                  wrem_nxt       = in_data.length - 1'b1;
                  wref_nxt       = 1'b0;
                  res_status_nxt = ST_OK;
                  res_count_nxt  = CNT_W'(1);
                  res_last_nxt   = (wrem_nxt == '0);
                  res_used_nxt   = used + 1'b1;
                  res_free_nxt   = free - 1'b1;
                end
              end else if (wrem_r == '0) begin
                // stray byte with no open transaction
                res_status_nxt = ST_REFUSED;
              end else if (wref_r) begin
                wrem_nxt       = wrem_r - 1'b1;
                wref_nxt       = (wrem_nxt != '0);
                res_status_nxt = ST_DROPPED;
                res_last_nxt   = (wrem_nxt == '0);
              end else begin
                wr_en          = 1'b1;
                head_nxt       = adv1(head_r);
                wrem_nxt       = wrem_r - 1'b1;
                res_status_nxt = ST_OK;
                res_count_nxt  = CNT_W'(1);
                res_last_nxt   = (wrem_nxt == '0);
                res_used_nxt   = used + 1'b1;
                res_free_nxt   = free - 1'b1;
              end
            end
            CMD_READ: begin
              if (in_data.length > used) begin
                res_status_nxt = ST_REFUSED;
              end else if (in_data.length == '0) begin
                res_status_nxt = ST_OK;
              end else begin
                // first byte issued now, the rest streamed from rd_ptr_r
                rd_en          = 1'b1;
                tail_nxt       = tail_adv;
                rd_ptr_nxt     = adv1(tail_r);
                rd_left_nxt    = in_data.length - 1'b1;
                res_status_nxt = ST_OK;
                res_count_nxt  = CNT_W'(1);
                res_last_nxt   = (rd_left_nxt == '0);
                res_used_nxt   = used - in_data.length;
                res_free_nxt   = free + in_data.length;
                res_rd_nxt     = 1'b1;
                if (rd_left_nxt != '0) begin
                  state_nxt = S_READ;
                end
              end
            end
            CMD_DROP: begin
              if (in_data.length > used) begin
                res_status_nxt = ST_REFUSED;
              end else begin
                tail_nxt       = tail_adv;
                res_status_nxt = ST_DROPPED;
                res_count_nxt  = in_data.length;
                res_used_nxt   = used - in_data.length;
                res_free_nxt   = free + in_data.length;
              end
            end
            default: begin
              res_status_nxt = ST_REFUSED;
            end
          endcase
        end
      end
      S_READ: begin
        out_vld_nxt   = 1'b1;
        rd_en         = 1'b1;
        rd_ptr_nxt    = adv1(rd_ptr_r);
        rd_left_nxt   = rd_left_r - 1'b1;
        res_count_nxt = res_count_r + 1'b1;
        res_last_nxt  = (rd_left_nxt == '0);
        if (rd_left_nxt == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      rd_left_r <= '0;
      wrem_r    <= '0;
      wref_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      rd_left_r <= rd_left_nxt;
      wrem_r    <= wrem_nxt;
      wref_r    <= wref_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r     <= rd_ptr_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
    res_last_r   <= res_last_nxt;
    res_used_r   <= res_used_nxt;
    res_free_r   <= res_free_nxt;
    res_rd_r     <= res_rd_nxt;
  end

  brb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(head_r),
    .wr_data(in_data.write_byte),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_valid = out_vld_r;

  always_comb begin
    out_data.status     = res_status_r;
    out_data.count      = res_count_r;
    out_data.read_byte  = res_rd_r ? rd_data : '0;
    out_data.last       = res_last_r;
    out_data.used_count = res_used_r;
    out_data.free_count = res_free_r;
  end

  `BRB_ASSERT_NEXT(a_accept_gives_result, accept, out_valid,
                   "accepted transaction gave no result")
  `BRB_ASSERT_NEXT(a_stream_gives_result, busy, out_valid && res_rd_r,
                   "streaming read cycle gave no byte")
  `BRB_ASSERT_SAME(a_stream_left, state_r == S_READ, rd_left_r != '0,
                   "read stream active with nothing left")
  `BRB_ASSERT_SAME(a_counts_sum, out_valid,
                   out_data.used_count + out_data.free_count == MAX_USED,
                   "used and free counts disagree")

endmodule

/* sim/tb_top.sv */
// self-checking testbench for the byte ring buffer: directed and random commands
`timescale 1ns / 1ps

module tb_top
  import brb_pkg::*;
();

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 286;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         TAIL_CYCLES  = 80;
  localparam int         MAX_REPORTS  = 10;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  brb_in_t  in_data;
  logic     out_valid;
  brb_out_t out_data;

  byte_ring_buffer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // shadow copy of the ring contents and transaction state
  logic [BYTE_W-1:0] ring_mem [DEPTH];
  logic [PTR_W-1:0]  ring_head;
  logic [PTR_W-1:0]  ring_tail;
  int                wr_left;
  bit                wr_refused;

  brb_out_t pending_results [$];
  int       n_fail;
  int       items_sent;
  int       burst_left;
  int       cycle_cnt;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic logic [CNT_W-1:0] ring_used();
    return ring_head - ring_tail;
  endfunction

  function automatic int ring_free();
    return (DEPTH - 1) - ring_used();
  endfunction

  function automatic brb_out_t mk_result(input status_t st, input logic [CNT_W-1:0] cnt,
                                         input logic [BYTE_W-1:0] b, input logic last);
    brb_out_t r;
    r = '0;
    r.status = st;
    r.count = cnt;
    r.read_byte = b;
    r.last = last;
    return r;
  endfunction

  function automatic brb_in_t make_item(input logic [1:0] cmd, input logic st,
                                        input logic [CNT_W-1:0] len,
                                        input logic [BYTE_W-1:0] b);
    brb_in_t it;
    it.cmd = cmd;
    it.start_req = st;
    it.length = len;
    it.write_byte = b;
    return it;
  endfunction

  // expected results of one accepted command, queued in order
  function automatic void predict_ring_step(input brb_in_t it);
    brb_out_t         batch [$];
    logic [CNT_W-1:0] used_after;
    batch = {};
    case (it.cmd)
      CMD_WRITE: begin
        if (it.start_req) begin
          if (it.length > ring_free()) begin
            wr_left = it.length - 1;
            wr_refused = (wr_left != 0);
            batch.push_back(mk_result(ST_REFUSED, 0, 0, wr_left == 0));
          end else if (it.length == 0) begin
            wr_refused = 1'b0;
            wr_left = 0;
            batch.push_back(mk_result(ST_OK, 0, 0, 1'b1));
          end else begin
            wr_refused = 1'b0;
            ring_mem[ring_head] = it.write_byte;
            ring_head = ring_head + 1'b1;
            wr_left = it.length - 1;
            batch.push_back(mk_result(ST_OK, 1, 0, wr_left == 0));
          end
        end else if (wr_left == 0) begin
          // stray byte outside any transaction
          batch.push_back(mk_result(ST_REFUSED, 0, 0, 1'b1));
        end else if (wr_refused) begin
          wr_left--;
          if (wr_left == 0) wr_refused = 1'b0;
          batch.push_back(mk_result(ST_DROPPED, 0, 0, wr_left == 0));
        end else begin
          ring_mem[ring_head] = it.write_byte;
          ring_head = ring_head + 1'b1;
          wr_left--;
          batch.push_back(mk_result(ST_OK, 1, 0, wr_left == 0));
        end
      end
      CMD_READ: begin
        if (it.length > ring_used()) begin
          batch.push_back(mk_result(ST_REFUSED, 0, 0, 1'b1));
        end else if (it.length == 0) begin
          batch.push_back(mk_result(ST_OK, 0, 0, 1'b1));
        end else begin
          for (int i = 1; i <= it.length; i++) begin
            batch.push_back(mk_result(ST_OK, i, ring_mem[ring_tail], i == it.length));
            ring_tail = ring_tail + 1'b1;
          end
        end
      end
      CMD_DROP: begin
        if (it.length > ring_used()) begin
          batch.push_back(mk_result(ST_REFUSED, 0, 0, 1'b1));
        end else begin
          ring_tail = ring_tail + it.length;
          batch.push_back(mk_result(ST_DROPPED, it.length, 0, 1'b1));
        end
      end
      default: begin
        batch.push_back(mk_result(ST_REFUSED, 0, 0, 1'b1));
      end
    endcase
    // counts reflect the state after the whole command
    used_after = ring_used();
    foreach (batch[k]) begin
      batch[k].used_count = used_after;
      batch[k].free_count = (DEPTH - 1) - used_after;
      pending_results.push_back(batch[k]);
    end
  endfunction

  // one transaction on the command port, with bursty idle gaps in between
  task automatic send_item(input brb_in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_ring_step(it);
    items_sent++;
  endtask

  always @(posedge clk) begin
    brb_out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("unexpected result: st=%0d cnt=%0d byte=%02h last=%0d used=%0d free=%0d",
                   out_data.status, out_data.count, out_data.read_byte, out_data.last,
                   out_data.used_count, out_data.free_count);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.count !== want.count ||
            out_data.read_byte !== want.read_byte || out_data.last !== want.last ||
            out_data.used_count !== want.used_count ||
            out_data.free_count !== want.free_count) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS) begin
            $write("mismatch: exp st=%0d cnt=%0d byte=%02h last=%0d used=%0d free=%0d",
                   want.status, want.count, want.read_byte, want.last,
                   want.used_count, want.free_count);
            $display(" got st=%0d cnt=%0d byte=%02h last=%0d used=%0d free=%0d",
                     out_data.status, out_data.count, out_data.read_byte, out_data.last,
                     out_data.used_count, out_data.free_count);
          end
        end
      end
    end
  end

  task automatic test_empty_buffer();
    send_item(make_item(CMD_READ, 1'b0, 0, 8'h00));
    send_item(make_item(CMD_READ, 1'b1, 1, 8'hff));
    send_item(make_item(CMD_DROP, 1'b0, 63, 8'h00));
  endtask

  task automatic test_write_then_read();
    send_item(make_item(CMD_WRITE, 1'b1, 3, 8'h00));
    send_item(make_item(CMD_WRITE, 1'b0, 63, 8'hff));
    send_item(make_item(CMD_WRITE, 1'b0, 0, 8'ha5));
    send_item(make_item(CMD_READ, 1'b0, 3, 8'h00));
  endtask

  task automatic test_zero_length();
    send_item(make_item(CMD_WRITE, 1'b1, 0, 8'h5a));
    send_item(make_item(CMD_DROP, 1'b1, 0, 8'h00));
  endtask

  task automatic test_refused_write();
    send_item(make_item(CMD_WRITE, 1'b1, 2, 8'h11));
    send_item(make_item(CMD_WRITE, 1'b0, 0, 8'h22));
    // too long for the free room, following bytes are discarded
    send_item(make_item(CMD_WRITE, 1'b1, 63, 8'h33));
    send_item(make_item(CMD_WRITE, 1'b0, 0, 8'h44));
    send_item(make_item(CMD_WRITE, 1'b0, 0, 8'h55));
    // a new start abandons the refused transaction
    send_item(make_item(CMD_WRITE, 1'b1, 1, 8'h66));
    send_item(make_item(CMD_DROP, 1'b0, 3, 8'h00));
  endtask

  task automatic test_stray_and_unused();
    send_item(make_item(CMD_WRITE, 1'b0, 5, 8'h77));
    send_item(make_item(CMD_UNUSED, 1'b1, 63, 8'hff));
  endtask

  task automatic test_interleave();
    send_item(make_item(CMD_WRITE, 1'b1, 3, 8'h81));
    send_item(make_item(CMD_READ, 1'b0, 1, 8'h00));
    send_item(make_item(CMD_WRITE, 1'b0, 0, 8'h82));
    send_item(make_item(CMD_DROP, 1'b0, 1, 8'h00));
    send_item(make_item(CMD_WRITE, 1'b0, 0, 8'h83));
    send_item(make_item(CMD_READ, 1'b0, 1, 8'h00));
  endtask

  task automatic test_random();
    int kind;
    int len;
    int room;
    int stop_at;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        room = ring_free();
        case ($urandom_range(0, 5))
          0:       len = $urandom_range(0, 63);
          1:       len = room;
          default: len = $urandom_range(0, (room < 8) ? room : 8);
        endcase
        send_item(make_item(CMD_WRITE, 1'b1, len, $urandom));
        for (int b = 1; b < len; b++) begin
          if ($urandom_range(0, 9) == 0)
            send_item(make_item($urandom_range(0, 1) ? CMD_READ : CMD_DROP,
                                $urandom_range(0, 1), $urandom_range(0, ring_used()),
                                $urandom));
          // occasionally leave the transaction unfinished
          if ($urandom_range(0, 39) == 0) break;
          send_item(make_item(CMD_WRITE, 1'b0, $urandom, $urandom));
        end
      end else if (kind < 88) begin
        case ($urandom_range(0, 4))
          0:       len = $urandom_range(0, 63);
          1:       len = ring_used();
          default: len = $urandom_range(0, ring_used());
        endcase
        send_item(make_item((kind < 73) ? CMD_READ : CMD_DROP, $urandom_range(0, 1),
                            len, $urandom));
      end else begin
        case ($urandom_range(0, 2))
          0:       send_item(make_item(CMD_WRITE, 1'b0, $urandom, $urandom));
          1:       send_item(make_item(CMD_UNUSED, $urandom_range(0, 1), $urandom, $urandom));
          default: send_item(make_item(CMD_WRITE, 1'b1, $urandom, $urandom));
        endcase
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    n_fail = 0;
    items_sent = 0;
    burst_left = 0;
    cycle_cnt = 0;
    ring_head = '0;
    ring_tail = '0;
    wr_left = 0;
    wr_refused = 1'b0;
    foreach (ring_mem[i]) ring_mem[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_buffer();
    test_write_then_read();
    test_zero_length();
    test_refused_write();
    test_stray_and_unused();
    test_interleave();
    test_random();

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (n_fail == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
